// File: design/rgb_led_time_mixer_unit_defines.svh
// Assertion macros used by the RGB LED time mixer core.
`ifndef RGB_LED_TIME_MIXER_UNIT_DEFINES_SVH
`define RGB_LED_TIME_MIXER_UNIT_DEFINES_SVH

// Checks that an expression holds at every clock edge outside of reset.
`define RLTM_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define RLTM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define RLTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rltm_pkg.sv
// Package with the word types, request codes and helpers of the RGB LED time mixer.
`default_nettype none

package rltm_pkg;

    // Width of the phase times and of the countdown.
    localparam int TIME_BITS = 8;

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_ON      = 3'd1,
        REQ_OFF     = 3'd2,
        REQ_MIX     = 3'd3,
        REQ_PRI_ON  = 3'd4,
        REQ_PRI_OFF = 3'd5
    } t_req_code;

    // Mix phase slots: dark first, then red, green and blue.
    typedef enum logic [1:0] {
        SLOT_DARK  = 2'd0,
        SLOT_RED   = 2'd1,
        SLOT_GREEN = 2'd2,
        SLOT_BLUE  = 2'd3
    } t_slot;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] red_value;
        logic [7:0] green_value;
        logic [7:0] blue_value;
        logic [7:0] dark_time;
    } t_in_word;

    typedef struct packed {
        logic pin_red;
        logic pin_green;
        logic pin_blue;
        logic priority_active;
        logic mixing;
    } t_out_word;

    // Fits an 8-bit request field to the time width, extending or truncating.
    function automatic t_time to_time(input logic [7:0] v);
        logic [TIME_BITS+7:0] w;
        w = {{TIME_BITS{1'b0}}, v};
        return w[TIME_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/rltm_in_stage.sv
// Input register of the RGB LED time mixer.
`default_nettype none

module rltm_in_stage (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  rltm_pkg::t_in_word    i_in_word,
    input  wire                   i_advance,
    output logic                  o_valid,
    output rltm_pkg::t_in_word    o_word
);

    logic               r_valid;
    rltm_pkg::t_in_word r_word;

    // The register may load whenever it is empty or its word moves on.
    assign o_in_ready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_word <= i_in_word;
        end
    end

endmodule

`default_nettype wire

// File: design/rltm_core.sv
// Mixer state and the next-state logic for one request word.
`default_nettype none
`include "rgb_led_time_mixer_unit_defines.svh"

module rltm_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_fire,
    input  rltm_pkg::t_in_word    i_word,
    output rltm_pkg::t_out_word   o_result
);

    logic                  r_run;
    logic [1:0]            r_slot;
    rltm_pkg::t_time       r_countdown;
    rltm_pkg::t_time       r_times [4];
    logic [2:0]            r_saved;
    logic                  r_mix;
    logic                  r_on;
    logic                  r_pri;
    logic [2:0]            r_pins;

    logic                  n_run;
    logic [1:0]            n_slot;
    rltm_pkg::t_time       n_countdown;
    rltm_pkg::t_time       n_times [4];
    logic [2:0]            n_saved;
    logic                  n_mix;
    logic                  n_on;
    logic                  n_pri;
    logic [2:0]            n_pins;

    logic [2:0]            colours;
    rltm_pkg::t_time       restart_wait;
    logic [3:0]            nonzero;
    logic                  found;
    logic [1:0]            hit;
    logic [1:0]            probe;
    rltm_pkg::t_time       hit_time;

    assign colours = {i_word.blue_value[0], i_word.green_value[0], i_word.red_value[0]};

    // First slot with a nonzero time, searching cyclically from r_slot.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            nonzero[k] = (r_times[k] != '0);
        end
        found = 1'b0;
        hit   = r_slot;
        probe = r_slot;
        for (int j = 0; j < 4; j++) begin
            probe = r_slot + 2'(j);
            if (!found && nonzero[probe]) begin
                found = 1'b1;
                hit   = probe;
            end
        end
        hit_time = r_times[hit];
    end

    // A restart waits for the dark time, or a single tick when it is zero.
    assign restart_wait = (r_times[rltm_pkg::SLOT_DARK] == '0) ?
                          rltm_pkg::t_time'(1) : r_times[rltm_pkg::SLOT_DARK];

    always_comb begin
        n_run       = r_run;
        n_slot      = r_slot;
        n_countdown = r_countdown;
        n_times     = r_times;
        n_saved     = r_saved;
        n_mix       = r_mix;
        n_on        = r_on;
        n_pri       = r_pri;
        n_pins      = r_pins;

        unique case (rltm_pkg::t_req_code'(i_word.req_type))
            rltm_pkg::REQ_TICK: begin
                if (r_run) begin
                    if (r_countdown > rltm_pkg::t_time'(1)) begin
                        n_countdown = r_countdown - rltm_pkg::t_time'(1);
                    end else if (found) begin
                        n_countdown = hit_time;
                        n_slot      = hit + 2'd1;
                        if (hit == rltm_pkg::SLOT_DARK) begin
                            n_pins = 3'b000;
                        end else begin
                            n_pins  = 3'b001 << (hit - 2'd1);
                            n_saved = 3'b001 << (hit - 2'd1);
                            n_on    = 1'b1;
                        end
                    end else begin
                        n_pins      = 3'b000;
                        n_run       = 1'b0;
                        n_countdown = '0;
                        n_mix       = 1'b0;
                        n_on        = 1'b0;
                    end
                end
            end
            rltm_pkg::REQ_ON: begin
                if (!r_pri) begin
                    n_saved = colours;
                    n_pins  = colours;
                    n_on    = 1'b1;
                end
            end
            rltm_pkg::REQ_OFF: begin
                if (!r_pri) begin
                    n_run  = 1'b0;
                    n_on   = 1'b0;
                    n_mix  = 1'b0;
                    n_pins = 3'b000;
                end
            end
            rltm_pkg::REQ_MIX: begin
                if (!r_pri) begin
                    n_times[rltm_pkg::SLOT_RED]   = rltm_pkg::to_time(i_word.red_value);
                    n_times[rltm_pkg::SLOT_GREEN] = rltm_pkg::to_time(i_word.green_value);
                    n_times[rltm_pkg::SLOT_BLUE]  = rltm_pkg::to_time(i_word.blue_value);
                    n_times[rltm_pkg::SLOT_DARK]  = rltm_pkg::to_time(i_word.dark_time);
                    n_mix       = 1'b1;
                    n_on        = 1'b1;
                    n_run       = 1'b1;
                    n_slot      = rltm_pkg::SLOT_RED;
                    n_countdown = (rltm_pkg::to_time(i_word.dark_time) == '0) ?
                                  rltm_pkg::t_time'(1) :
                                  rltm_pkg::to_time(i_word.dark_time);
                end
            end
            rltm_pkg::REQ_PRI_ON: begin
                n_run  = 1'b0;
                n_pins = colours;
                n_pri  = 1'b1;
            end
            rltm_pkg::REQ_PRI_OFF: begin
                n_pri = 1'b0;
                if (r_on) begin
                    if (r_mix) begin
                        n_run       = 1'b1;
                        n_slot      = rltm_pkg::SLOT_RED;
                        n_countdown = restart_wait;
                    end else begin
                        n_pins = r_saved;
                    end
                end else begin
                    n_pins = 3'b000;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_slot      <= rltm_pkg::SLOT_RED;
            r_countdown <= '0;
            for (int k = 0; k < 4; k++) begin
                r_times[k] <= '0;
            end
            r_saved     <= 3'b000;
            r_mix       <= 1'b0;
            r_on        <= 1'b0;
            r_pri       <= 1'b0;
            r_pins      <= 3'b000;
        end else if (i_fire) begin
            r_run       <= n_run;
            r_slot      <= n_slot;
            r_countdown <= n_countdown;
            r_times     <= n_times;
            r_saved     <= n_saved;
            r_mix       <= n_mix;
            r_on        <= n_on;
            r_pri       <= n_pri;
            r_pins      <= n_pins;
        end
    end

    assign o_result.pin_red         = n_pins[0];
    assign o_result.pin_green       = n_pins[1];
    assign o_result.pin_blue        = n_pins[2];
    assign o_result.priority_active = n_pri;
    assign o_result.mixing          = n_run;

    `RLTM_ASSERT_IMPLIES(a_run_has_flags, i_clk, i_rst_n, r_run, r_mix && r_on,
        "running mix without mix and on flags")
    `RLTM_ASSERT_IMPLIES(a_pri_stops_mix, i_clk, i_rst_n, r_pri, !r_run,
        "mix running while priority colours are held")
    `RLTM_ASSERT_IMPLIES(a_run_countdown, i_clk, i_rst_n, r_run, r_countdown != '0,
        "running mix with an empty countdown")
    `RLTM_ASSERT_NEXT(a_pri_on_sets, i_clk, i_rst_n,
        i_fire && (i_word.req_type == rltm_pkg::REQ_PRI_ON), r_pri,
        "priority request did not set the priority flag")

endmodule

`default_nettype wire

// File: design/rltm_out_stage.sv
// Result register of the RGB LED time mixer.
`default_nettype none

module rltm_out_stage (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_fire,
    input  rltm_pkg::t_out_word   i_result,
    output logic                  o_advance,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output rltm_pkg::t_out_word   o_out_word
);

    logic                r_valid;
    rltm_pkg::t_out_word r_word;

    // A new result may enter when the register is empty or being read out.
    assign o_advance   = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_word <= i_result;
        end
    end

endmodule

`default_nettype wire

// File: design/rgb_led_time_mixer_unit.sv
// An accepted word waits in the input register until the result register has room.
// Throughput: one word per cycle; both registers advance together, gated by result ready.
// The mix state is updated once per word, in the cycle the word enters the result register.
// Reset (i_rst_n low at a clock edge) empties both registers, stops the mix, clears all
// flags, times and saved colours, and turns all three pins off.
`default_nettype none

module rgb_led_time_mixer_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  rltm_pkg::t_in_word    i_in_word,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output rltm_pkg::t_out_word   o_out_word
);

    // The input register holds one request word. When the result register can take
    // a word, the held request is applied to the mixer state and its result is
    // captured, so every request yields exactly one result word in order.
    logic                 in_valid;
    rltm_pkg::t_in_word   in_word;
    logic                 advance;
    logic                 fire;
    rltm_pkg::t_out_word  result;

    // A request is applied only when it is present and its result has room.
    assign fire = in_valid && advance;

    rltm_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_advance  (advance),
        .o_valid    (in_valid),
        .o_word     (in_word)
    );

    // The core holds the pins, flags, saved colours, mix times and countdown. Tick
    // words step the countdown; when it runs out the next slot with a nonzero time
    // is found by a four-way cyclic search and shown; if there is none, the mix stops.
    rltm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_word   (in_word),
        .o_result (result)
    );

    rltm_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_result    (result),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// File: bench/rltm_output_checker.sv
// Result checker for the RGB LED time mixer: predicts every result word and compares it.
module rltm_output_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_ready,
    input  rltm_pkg::t_in_word  i_in_word,
    input  wire                 i_out_valid,
    input  wire                 i_out_ready,
    input  rltm_pkg::t_out_word i_out_word,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    import rltm_pkg::*;

    localparam logic [2:0] SLOT_IDLE = 3'd4;

    // Predicted mixer state.
    logic [2:0] slot_next;
    t_time      ticks_left;
    t_time      slot_time [4];
    logic [2:0] steady_colours;
    logic [2:0] pin_state;
    bit         mix_run;
    bit         lit_on;
    bit         pri_hold;

    t_out_word  expected_levels [$];
    int         fails;
    int         checked;
    string      field_name [5] = '{"pin_red", "pin_green", "pin_blue",
                                   "priority_active", "mixing"};

    // Arms the mix: the first wait is the dark time, or one tick when that is zero.
    function automatic void arm_mix();
        mix_run   = 1'b1;
        lit_on    = 1'b1;
        slot_next = {1'b0, SLOT_RED};
        ticks_left = (slot_time[SLOT_DARK] == '0) ? t_time'(1) : slot_time[SLOT_DARK];
    endfunction

    function automatic t_out_word mixer_step(input t_in_word w);
        t_out_word  r;
        logic [2:0] colours;
        logic [1:0] s;
        bit         found;
        colours = {w.blue_value[0], w.green_value[0], w.red_value[0]};
        case (w.req_type)
            REQ_TICK: begin
                if (slot_next != SLOT_IDLE) begin
                    if (ticks_left > t_time'(1)) begin
                        ticks_left = ticks_left - t_time'(1);
                    end else begin
                        // Walk the slots cyclically and show the first one with a time.
                        s = slot_next[1:0];
                        found = 1'b0;
                        for (int k = 0; k < 4; k++) begin
                            if (!found && slot_time[s] != '0) begin
                                found = 1'b1;
                                if (s == SLOT_DARK) begin
                                    pin_state = '0;
                                end else begin
                                    pin_state = 3'b001 << (s - 2'd1);
                                    steady_colours = pin_state;
                                    lit_on = 1'b1;
                                end
                                ticks_left = slot_time[s];
                                slot_next = {1'b0, s + 2'd1};
                            end else if (!found) begin
                                s = s + 2'd1;
                            end
                        end
                        if (!found) begin
                            pin_state  = '0;
                            slot_next  = SLOT_IDLE;
                            ticks_left = '0;
                            mix_run    = 1'b0;
                            lit_on     = 1'b0;
                        end
                    end
                end
            end
            REQ_ON: begin
                if (!pri_hold) begin
                    steady_colours = colours;
                    pin_state = colours;
                    lit_on = 1'b1;
                end
            end
            REQ_OFF: begin
                if (!pri_hold) begin
                    slot_next = SLOT_IDLE;
                    lit_on    = 1'b0;
                    mix_run   = 1'b0;
                    pin_state = '0;
                end
            end
            REQ_MIX: begin
                if (!pri_hold) begin
                    slot_time[SLOT_RED]   = t_time'(w.red_value);
                    slot_time[SLOT_GREEN] = t_time'(w.green_value);
                    slot_time[SLOT_BLUE]  = t_time'(w.blue_value);
                    slot_time[SLOT_DARK]  = t_time'(w.dark_time);
                    arm_mix();
                end
            end
            REQ_PRI_ON: begin
                slot_next = SLOT_IDLE;
                pin_state = colours;
                pri_hold  = 1'b1;
            end
            REQ_PRI_OFF: begin
                pri_hold = 1'b0;
                if (lit_on) begin
                    if (mix_run) begin
                        arm_mix();
                    end else begin
                        pin_state = steady_colours;
                    end
                end else begin
                    pin_state = '0;
                end
            end
            default: begin
            end
        endcase
        r.pin_red         = pin_state[0];
        r.pin_green       = pin_state[1];
        r.pin_blue        = pin_state[2];
        r.priority_active = pri_hold;
        r.mixing          = (slot_next != SLOT_IDLE);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            slot_next      = SLOT_IDLE;
            ticks_left     = '0;
            for (int k = 0; k < 4; k++) slot_time[k] = '0;
            steady_colours = '0;
            pin_state      = '0;
            mix_run        = 1'b0;
            lit_on         = 1'b0;
            pri_hold       = 1'b0;
            expected_levels.delete();
        end else begin
            // Results are checked first: a word passes both registers before it leaves.
            if (i_out_valid && i_out_ready) begin
                got = i_out_word;
                if (expected_levels.size() == 0) begin
                    $display("%0t: result word %b arrived with no prediction waiting",
                             $time, got);
                    fails++;
                end else begin
                    want = expected_levels.pop_front();
                    for (int f = 0; f < 5; f++) begin
                        if (want[4-f] !== got[4-f]) begin
                            $display("%0t: %s mismatch, expected %b actual %b",
                                     $time, field_name[f], want[4-f], got[4-f]);
                            fails++;
                        end
                    end
                    checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_levels.push_back(mixer_step(i_in_word));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_levels.size();
        o_checked    <= checked;
    end

endmodule

// File: bench/tb_rgb_led_time_mixer_unit.sv
// Testbench top for the RGB LED time mixer: stimulus, handshake jitter and the verdict.
module tb_rgb_led_time_mixer_unit;
    import rltm_pkg::*;

    // Request codes that the block must ignore.
    localparam logic [2:0] REQ_UNUSED_A = 3'd6;
    localparam logic [2:0] REQ_UNUSED_B = 3'd7;

    // Cycles without a word moving on either channel before the run is declared hung.
    localparam int STALL_LIMIT = 4000;

    // Least number of request words to send, directed part included.
    localparam int WORD_TARGET = 1340;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    t_in_word  in_word;
    logic      in_ready;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;

    int        fail_count;
    int        pending;
    int        checked;

    // When set, both sides drop their handshake at random.
    bit        jitter_on;
    int        quiet_cycles;
    int        words_sent;
    int        req_seen [8];

    rgb_led_time_mixer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    rltm_output_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    // While jitter is enabled the receiver stalls at random, with a chance of about 17 in a hundred.
    always @(posedge i_clk) begin
        out_ready <= !(jitter_on && $urandom_range(99) < 17);
    end

    // Watchdog: any cycle that moves a word on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without a word moving", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // Mix times are mostly tiny so that the phases turn over quickly; now and then a
    // full-range value keeps every bit of the time fields moving.
    function automatic logic [7:0] mix_time();
        if ($urandom_range(99) < 15) begin
            return rand_byte();
        end
        return 8'($urandom_range(3));
    endfunction

    // Presents one request word and returns at the edge where it is accepted. Valid
    // holds steady from the moment it rises until that edge.
    task automatic send_word(input logic [2:0] req, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] d);
        t_in_word w;
        w.req_type    = req;
        w.red_value   = r;
        w.green_value = g;
        w.blue_value  = b;
        w.dark_time   = d;
        while (jitter_on && $urandom_range(99) < 17) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        req_seen[req] = req_seen[req] + 1;
        words_sent++;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Stops sending and waits until every predicted result has been checked. The first
    // edge lets the checker count the word accepted at the edge we returned on.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int  pick;
        int  run_len;
        bit  pressure_done;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        jitter_on = 1'b1;
        words_sent    = 0;
        pressure_done = 1'b0;
        for (int k = 0; k < 8; k++) req_seen[k] = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A tick while idle must do nothing at all.
        send_word(REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        // Steady colours take only bit 0 of each value.
        send_word(REQ_ON, 8'hff, 8'hff, 8'hff, 8'hff);
        send_word(REQ_ON, 8'hfe, 8'hff, 8'hfe, 8'h00);
        send_word(REQ_OFF, 8'hff, 8'hff, 8'hff, 8'hff);
        // The two unused request codes only report the current state.
        send_word(REQ_UNUSED_A, 8'hff, 8'hff, 8'hff, 8'hff);
        send_word(REQ_UNUSED_B, 8'h00, 8'h00, 8'h00, 8'h00);
        // A mix with a zero dark time waits one tick, then skips the empty blue and
        // dark slots on its way back to red.
        send_word(REQ_MIX, 8'd1, 8'd2, 8'd0, 8'd0);
        repeat (5) send_word(REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        // Steady colours during a mix change the pins until the next phase.
        send_word(REQ_ON, 8'h00, 8'h01, 8'h00, 8'h00);
        // Priority colours stop the mix; steady, off and mix requests are then ignored.
        send_word(REQ_PRI_ON, 8'h01, 8'h00, 8'h01, 8'h00);
        send_word(REQ_ON, 8'hff, 8'hff, 8'hff, 8'h00);
        send_word(REQ_OFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(REQ_MIX, 8'hff, 8'hff, 8'hff, 8'hff);
        send_word(REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        // Releasing priority with the mix flag set restarts the mix.
        send_word(REQ_PRI_OFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        // With every mix time zero the first phase change goes dark and stops.
        send_word(REQ_MIX, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        // Release without any priority held, and with nothing lit, goes dark.
        send_word(REQ_PRI_OFF, 8'hff, 8'hff, 8'hff, 8'hff);
        // Release with only steady colours saved brings them back over the pins.
        send_word(REQ_ON, 8'h01, 8'h01, 8'h00, 8'h00);
        send_word(REQ_PRI_ON, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(REQ_PRI_OFF, 8'h00, 8'h00, 8'h00, 8'h00);
        // Largest times: the countdown starts at its top value.
        send_word(REQ_MIX, 8'hff, 8'hff, 8'hff, 8'hff);
        send_word(REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);

        // Random part, built from episodes. Most are a mix start followed by a run of
        // ticks with an occasional stray request; some wrap a priority grant around
        // ignored requests; the rest are single words of any code.
        while (words_sent < WORD_TARGET) begin
            // A long stretch in the middle runs with no handshake jitter at all.
            jitter_on = (words_sent < 500 || words_sent >= 800);
            if (!pressure_done && words_sent >= 950) begin
                drain_results();
                pressure_done = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_word(REQ_MIX, mix_time(), mix_time(), mix_time(), mix_time());
                run_len = $urandom_range(40, 8);
                repeat (run_len) begin
                    if ($urandom_range(99) < 10) begin
                        send_word(3'($urandom_range(7)), rand_byte(), rand_byte(),
                                  rand_byte(), rand_byte());
                    end else begin
                        send_word(REQ_TICK, rand_byte(), rand_byte(), rand_byte(),
                                  rand_byte());
                    end
                end
            end else if (pick < 75) begin
                send_word(REQ_PRI_ON, rand_byte(), rand_byte(), rand_byte(), rand_byte());
                run_len = $urandom_range(5);
                repeat (run_len) begin
                    send_word(3'($urandom_range(3)), rand_byte(), rand_byte(),
                              rand_byte(), rand_byte());
                end
                send_word(REQ_PRI_OFF, rand_byte(), rand_byte(), rand_byte(), rand_byte());
            end else begin
                send_word(3'($urandom_range(7)), rand_byte(), rand_byte(), rand_byte(),
                          rand_byte());
            end
        end

        // Let every prediction be met, then give the two-stage pipe time to show any
        // stray word before judging.
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d request words: %0d ticks, %0d steady, %0d off, %0d mix starts,",
                 words_sent, req_seen[REQ_TICK], req_seen[REQ_ON], req_seen[REQ_OFF],
                 req_seen[REQ_MIX]);
        $display("%0d priority grants, %0d releases, %0d unused codes; %0d results compared.",
                 req_seen[REQ_PRI_ON], req_seen[REQ_PRI_OFF],
                 req_seen[REQ_UNUSED_A] + req_seen[REQ_UNUSED_B], checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
